// ===== rtl/core/pcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pcfd_pkg
// Shared types and constants of the per-client flood detector.
// ----------------------------------------------------------------------------
`default_nettype none

package pcfd_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int HIST_DEPTH    = 16;
	localparam int HIST_W        = $clog2(HIST_DEPTH);
	localparam int FILL_W        = HIST_W + 1;
	localparam int STAMP_ADDR_W  = IDX_W + HIST_W;

	localparam logic [1:0] REG_MAX_COUNT = 2'd0;
	localparam logic [1:0] REG_WINDOW    = 2'd1;
	localparam logic [1:0] REG_HOLD_TIME = 2'd2;

	localparam logic CMD_PUSH  = 1'b0;
	localparam logic CMD_SWEEP = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_META,
		ST_OLD,
		ST_WRITE,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/core/per_client_flood_detector_core.sv =====
// ----------------------------------------------------------------------------
// per_client_flood_detector_core
// Client table with per-client timestamp rings and sliding-window check.
// ----------------------------------------------------------------------------
// Each request takes one pass over the client table, one entry per cycle
// through the id and last-seen memories. The walk ends once the last read
// has drained through the compare stage. A decision step and the load of
// the output register follow. A push that finds its client or a free entry
// first reads the entry's ring state and oldest stamp and writes back, in
// the meta, old and write steps, before its result is loaded. One request
// is in work at a time; a new request is taken as soon as the previous
// result sits in the output register, even if that result is still stalled.
`default_nettype none

module per_client_flood_detector_core
	import pcfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        cmd,
	input  wire logic [63:0] client_id,
	input  wire logic [31:0] now_ms,
	input  wire logic        check_flood,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             flood_suspect,
	output logic             table_full,
	output logic [6:0]       removed_count
);

	localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(TABLE_ENTRIES);

	state_t state_q, state_d;

	logic [4:0]  max_count_q;
	logic [15:0] window_q;
	logic [31:0] hold_q;

	logic        cmd_q, check_q;
	logic [63:0] id_q;
	logic [31:0] now_q;

	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [IDX_W:0]   issue_q;
	logic             chk_s1;
	logic [IDX_W-1:0] chk_idx_s1;
	logic             hit_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q, entry_q;
	logic             new_q;
	logic [6:0]       removed_q;
	logic [FILL_W-1:0] fill_q;
	logic [HIST_W-1:0] head_q;

	logic flood_q, full_q;

	// Memories.
	logic [63:0] client_mem [TABLE_ENTRIES];
	logic [31:0] seen_mem   [TABLE_ENTRIES];
	logic [FILL_W+HIST_W-1:0] meta_mem [TABLE_ENTRIES];
	logic [31:0] stamp_mem  [TABLE_ENTRIES*HIST_DEPTH];

	logic [63:0] client_rd_s1;
	logic [31:0] seen_rd_s1;
	logic [FILL_W+HIST_W-1:0] meta_rd_s1;
	logic [31:0] stamp_rd_s1;

	// Datapath signals.
	logic              accept;
	logic [FILL_W-1:0] m_eff;
	logic [FILL_W-1:0] fill_eff;
	logic [HIST_W-1:0] head_eff;
	logic              drop_old;
	logic [FILL_W-1:0] fill_new;
	logic [HIST_W-1:0] head_new;
	logic [HIST_W-1:0] wr_pos;
	logic [31:0]       age_old;
	logic              flood_now;
	logic              write_en;
	logic              load_out;

	assign accept = in_valid && !in_stall;

	always_comb begin
		if (max_count_q == 5'd0) begin
			m_eff = FILL_W'(1);
		end else if (32'(max_count_q) > HIST_DEPTH) begin
			m_eff = FILL_W'(HIST_DEPTH);
		end else begin
			m_eff = FILL_W'(max_count_q);
		end
	end

	// Ring state of the chosen entry; a new client starts empty.
	assign fill_eff = new_q ? '0 : meta_rd_s1[FILL_W+HIST_W-1:HIST_W];
	assign head_eff = new_q ? '0 : meta_rd_s1[HIST_W-1:0];

	// Dropping the oldest stamp moves the head up by one and the fill down by
	// one, so the new stamp lands at head plus fill in both cases.
	assign drop_old  = (fill_q >= m_eff);
	assign head_new  = drop_old ? head_q + HIST_W'(1) : head_q;
	assign fill_new  = drop_old ? fill_q : fill_q + FILL_W'(1);
	assign wr_pos    = head_q + fill_q[HIST_W-1:0];
	assign age_old   = now_q - stamp_rd_s1;
	assign flood_now = check_q && drop_old && (age_old < {16'd0, window_q});

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		write_en = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (issue_q == SCAN_END && !chk_s1) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (cmd_q == CMD_PUSH && (hit_q || free_q)) begin
					state_d = ST_META;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_META:  state_d = ST_OLD;
			ST_OLD:   state_d = ST_WRITE;
			ST_WRITE: begin
				write_en = 1'b1;
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid || !out_stall) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q <= 5'd16;
			window_q    <= 16'd1000;
			hold_q      <= 32'd60000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_COUNT: max_count_q <= cfg_data[4:0];
				REG_WINDOW:    window_q    <= cfg_data[15:0];
				REG_HOLD_TIME: hold_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Table walk, entry bookkeeping and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			issue_q   <= '0;
			chk_s1    <= 1'b0;
			hit_q     <= 1'b0;
			free_q    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				issue_q <= '0;
				chk_s1  <= 1'b0;
				hit_q   <= 1'b0;
				free_q  <= 1'b0;
			end else if (state_q == ST_SCAN) begin
				chk_s1 <= (issue_q != SCAN_END);
				if (issue_q != SCAN_END) begin
					issue_q <= issue_q + (IDX_W + 1)'(1);
				end
				if (chk_s1) begin
					if (cmd_q == CMD_SWEEP) begin
						if (valid_q[chk_idx_s1] && (hold_q < now_q - seen_rd_s1)) begin
							valid_q[chk_idx_s1] <= 1'b0;
						end
					end else if (valid_q[chk_idx_s1]) begin
						if (!hit_q && client_rd_s1 == id_q) begin
							hit_q <= 1'b1;
						end
					end else if (!free_q) begin
						free_q <= 1'b1;
					end
				end
			end
			if (write_en) begin
				valid_q[entry_q] <= 1'b1;
			end
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			id_q      <= client_id;
			now_q     <= now_ms;
			check_q   <= check_flood;
			removed_q <= '0;
			flood_q   <= 1'b0;
			full_q    <= 1'b0;
		end
		if (state_q == ST_SCAN) begin
			chk_idx_s1 <= issue_q[IDX_W-1:0];
			if (chk_s1) begin
				if (cmd_q == CMD_SWEEP) begin
					if (valid_q[chk_idx_s1] && (hold_q < now_q - seen_rd_s1)) begin
						removed_q <= removed_q + 7'd1;
					end
				end else if (valid_q[chk_idx_s1]) begin
					if (!hit_q && client_rd_s1 == id_q) begin
						hit_idx_q <= chk_idx_s1;
					end
				end else if (!free_q) begin
					free_idx_q <= chk_idx_s1;
				end
			end
		end
		if (state_q == ST_DECIDE) begin
			entry_q <= hit_q ? hit_idx_q : free_idx_q;
			new_q   <= !hit_q;
			full_q  <= (cmd_q == CMD_PUSH) && !hit_q && !free_q;
		end
		if (state_q == ST_OLD) begin
			fill_q <= fill_eff;
			head_q <= head_eff;
		end
		if (write_en) begin
			flood_q <= flood_now;
		end
		if (load_out) begin
			flood_suspect <= flood_q;
			table_full    <= full_q;
			removed_count <= removed_q;
		end
	end

	always_ff @(posedge clk) begin
		client_rd_s1 <= client_mem[issue_q[IDX_W-1:0]];
		if (write_en && new_q) begin
			client_mem[entry_q] <= id_q;
		end
	end

	always_ff @(posedge clk) begin
		seen_rd_s1 <= seen_mem[issue_q[IDX_W-1:0]];
		if (write_en) begin
			seen_mem[entry_q] <= now_q;
		end
	end

	always_ff @(posedge clk) begin
		meta_rd_s1 <= meta_mem[entry_q];
		if (write_en) begin
			meta_mem[entry_q] <= {fill_new, head_new};
		end
	end

	always_ff @(posedge clk) begin
		stamp_rd_s1 <= stamp_mem[{entry_q, head_eff}];
		if (write_en) begin
			stamp_mem[{entry_q, wr_pos}] <= now_q;
		end
	end

	// A dropped push reports a full table and nothing else.
	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> !flood_suspect && removed_count == 7'd0)
		else $error("full table reported together with other results");

	a_new_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result appeared outside the completion step");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> in_stall)
		else $error("request taken while another is in work");

	a_sweep_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> removed_count <= 7'(TABLE_ENTRIES))
		else $error("removed count exceeds table size");

endmodule

`default_nettype wire
